### rtl/mpc_pkg.sv
// Shared constants and types for the midpoint circle rasterizer.
package mpc_pkg;

   // Width of the center and radius fields.
   localparam int COORD_BITS = 10;
   // Width of the emitted pixel coordinates, fixed by the result format.
   localparam int PIX_BITS = 12;
   // Octant point width: one more than a coordinate so that y may reach -1.
   localparam int STEP_BITS = COORD_BITS + 1;
   // Decision variable width: holds 3 - 2r and its growth exactly.
   localparam int DEC_BITS = COORD_BITS + 6;
   // Job queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   // One phase for each of the eight symmetric pixels.
   localparam int PHASE_BITS = 3;
   localparam logic [PHASE_BITS-1:0] PHASE_LAST = '1;

   // Request actions.
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP = 1'b1;

   // One unit of back-end work: eight pixels of a point, or one done marker.
   typedef struct packed {
      logic done;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic signed [STEP_BITS-1:0] point_x;
      logic signed [STEP_BITS-1:0] point_y;
   } job_type;

endpackage

### rtl/mpc_front.sv
// Front end: takes requests, keeps the circle state and issues one job per step.
module mpc_front import mpc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   input  logic req_action,
   input  logic [COORD_BITS-1:0] req_radius,
   input  logic [COORD_BITS-1:0] req_center_x,
   input  logic [COORD_BITS-1:0] req_center_y,
   input  logic queue_full,
   output logic job_push,
   output job_type job
);

   logic active_ff, active_in;
   logic signed [STEP_BITS-1:0] step_x_ff, step_x_in;
   logic signed [STEP_BITS-1:0] step_y_ff, step_y_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic [COORD_BITS-1:0] center_y_ff, center_y_in;

   logic accept;
   logic signed [DEC_BITS-1:0] x_wide;
   logic signed [DEC_BITS-1:0] y_wide;
   logic signed [DEC_BITS-1:0] r_wide;

   assign accept = req_push && !queue_full;
   assign x_wide = DEC_BITS'(step_x_ff);
   assign y_wide = DEC_BITS'(step_y_ff);
   assign r_wide = signed'(DEC_BITS'(req_radius));

   // Job issue: every accepted step sends a job, drawing or done.
   always_comb begin
      job_push = accept && (req_action == ACTION_STEP);
      job.done = !active_ff;
      job.center_x = center_x_ff;
      job.center_y = center_y_ff;
      job.point_x = step_x_ff;
      job.point_y = step_y_ff;
   end

   // Circle state update: start loads, a drawing step advances the midpoint.
   always_comb begin
      active_in = active_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      decision_in = decision_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (accept && (req_action == ACTION_START)) begin
         center_x_in = req_center_x;
         center_y_in = req_center_y;
         step_x_in = '0;
         step_y_in = STEP_BITS'(signed'({1'b0, req_radius}));
         decision_in = DEC_BITS'(3) - (r_wide <<< 1);
         active_in = 1'b1;
      end else if (accept && active_ff) begin
         if (decision_ff[DEC_BITS-1]) begin
            decision_in = decision_ff + (x_wide <<< 2) + DEC_BITS'(6);
         end else begin
            decision_in = decision_ff + ((x_wide - y_wide) <<< 2) + DEC_BITS'(10);
            step_y_in = step_y_ff - STEP_BITS'(1);
         end
         step_x_in = step_x_ff + STEP_BITS'(1);
         active_in = !(step_x_in > step_y_in);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Circle payload state.
   always_ff @(posedge clock) begin
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      decision_ff <= decision_in;
      center_x_ff <= center_x_in;
      center_y_ff <= center_y_in;
   end

endmodule

### rtl/mpc_queue.sv
// Short job queue that decouples the front end from the pixel back end.
module mpc_queue import mpc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  job_type push_job,
   output logic full,
   input  logic pop,
   output logic head_valid,
   output job_type head_job
);

   job_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_BITS+1)'(1);
      end
   end

   // Queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/mpc_back.sv
// Back end: expands each job into its symmetric pixels or a done marker, one per cycle unless the response stalls.
module mpc_back import mpc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  job_type head_job,
   output logic head_pop,
   input  logic rsp_pop,
   output logic rsp_empty,
   output logic signed [PIX_BITS-1:0] rsp_pixel_x,
   output logic signed [PIX_BITS-1:0] rsp_pixel_y,
   output logic rsp_last,
   output logic rsp_done_res
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic out_valid_ff, out_valid_in;
   logic signed [PIX_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic signed [PIX_BITS-1:0] pixel_y_ff, pixel_y_in;
   logic last_ff, last_in;
   logic done_ff, done_in;

   logic load;
   logic signed [STEP_BITS-1:0] off_a, off_b;
   logic signed [PIX_BITS-1:0] ext_a, ext_b, base_x, base_y;

   // A new pixel is produced when the output register is free or drains.
   assign load = head_valid && (!out_valid_ff || rsp_pop);

   // Phase bit 2 swaps x and y, bit 1 negates the y term, bit 0 the x term.
   always_comb begin
      off_a = phase_ff[2] ? head_job.point_y : head_job.point_x;
      off_b = phase_ff[2] ? head_job.point_x : head_job.point_y;
      ext_a = PIX_BITS'(off_a);
      ext_b = PIX_BITS'(off_b);
      base_x = signed'(PIX_BITS'(head_job.center_x));
      base_y = signed'(PIX_BITS'(head_job.center_y));
   end

   // Next pixel and phase.
   always_comb begin
      phase_in = phase_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      last_in = last_ff;
      done_in = done_ff;
      head_pop = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         done_in = head_job.done;
         if (head_job.done) begin
            pixel_x_in = '0;
            pixel_y_in = '0;
            last_in = 1'b1;
            head_pop = 1'b1;
         end else begin
            pixel_x_in = phase_ff[0] ? base_x - ext_a : base_x + ext_a;
            pixel_y_in = phase_ff[1] ? base_y - ext_b : base_y + ext_b;
            last_in = (phase_ff == PHASE_LAST);
            head_pop = (phase_ff == PHASE_LAST);
            phase_in = phase_ff + PHASE_BITS'(1);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_pixel_x = pixel_x_ff;
   assign rsp_pixel_y = pixel_y_ff;
   assign rsp_last = last_ff;
   assign rsp_done_res = done_ff;

endmodule

### rtl/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: front end, job queue, back end.
//
//   Channel   Handshake          Fields
//   request   req_push/req_full  action, radius, center_x, center_y
//   response  rsp_pop/rsp_empty  pixel_x, pixel_y, last, done_res
//
// A start request produces nothing. A drawing step yields eight pixels from the
// back end; a step with no circle yields one done marker. The back end's
// one-pixel-per-cycle output register sets the sustained rate when not stalled.
// Up to four steps queue between front and back, so requests keep flowing while
// the response side stalls. Reset is synchronous and leaves no circle active.
module midpoint_circle_rasterizer import mpc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_action,
   input  logic [COORD_BITS-1:0] req_radius,
   input  logic [COORD_BITS-1:0] req_center_x,
   input  logic [COORD_BITS-1:0] req_center_y,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic signed [PIX_BITS-1:0] rsp_pixel_x,
   output logic signed [PIX_BITS-1:0] rsp_pixel_y,
   output logic rsp_last,
   output logic rsp_done_res
);

   logic job_push, head_valid, head_pop;
   job_type job, head_job;

   // Request side.
   mpc_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_action(req_action),
      .req_radius(req_radius),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .queue_full(req_full),
      .job_push(job_push),
      .job(job)
   );

   // Decoupling queue.
   mpc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_job(job),
      .full(req_full),
      .pop(head_pop),
      .head_valid(head_valid),
      .head_job(head_job)
   );

   // Pixel side.
   mpc_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_job(head_job),
      .head_pop(head_pop),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_last(rsp_last),
      .rsp_done_res(rsp_done_res)
   );

endmodule

### rtl/mpc_checker.sv
// Port-level checks for the midpoint circle rasterizer and their binding.
module mpc_checker import mpc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic signed [PIX_BITS-1:0] rsp_pixel_x,
   input logic signed [PIX_BITS-1:0] rsp_pixel_y,
   input logic rsp_last,
   input logic rsp_done_res
);

   // Reset leaves no response waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response pending after reset");

   // Reset leaves room for requests.
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // A done marker is a single zero pixel closing its request.
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |->
         (rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_last))
      else $error("done response with nonzero pixel or without last");

   // A stalled response holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
          && $stable(rsp_last) && $stable(rsp_done_res)))
      else $error("stalled response changed");

endmodule

bind midpoint_circle_rasterizer mpc_checker u_mpc_checker (
   .clock(clock),
   .reset(reset),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_pixel_x(rsp_pixel_x),
   .rsp_pixel_y(rsp_pixel_y),
   .rsp_last(rsp_last),
   .rsp_done_res(rsp_done_res)
);
